>>> hdl/dbhi_pkg.sv
`default_nettype none
package dbhi_pkg;

    localparam int FRACTION_BITS = 4;
    localparam int T_W = 13;
    localparam int H_W = 11;
    localparam int HI_W = 15;
    localparam int DB_W = 8;
    localparam int ACC_W = 64;
    localparam int V_W = 24;
    localparam int SQ_W = 16;
    localparam int PC_W = 6;
    localparam int CNT_W = 6;

    localparam longint D = longint'(1) << FRACTION_BITS;
    localparam longint D2 = D * D;
    localparam longint D3 = D2 * D;
    localparam longint D4 = D3 * D;

    localparam logic signed [T_W-1:0] T80 = T_W'(80 * D);
    localparam logic signed [T_W-1:0] T112 = T_W'(112 * D);
    localparam logic signed [T_W:0] T95 = (T_W + 1)'(95 * D);
    localparam logic [T_W-1:0] T17 = T_W'(17 * D);
    localparam logic [T_W-1:0] H13 = T_W'(13 * D);

    localparam logic signed [V_W-1:0] HI_MIN = -24'sd4096;
    localparam logic signed [V_W-1:0] HI_MAX = 24'sd16383;

    localparam logic [PC_W-1:0] PC_ROTH = 6'd0;
    localparam logic [PC_W-1:0] PC_SIMPLE = 6'd23;
    localparam logic [PC_W-1:0] PC_FIN = 6'd31;
    localparam logic [PC_W-1:0] PC_LOWHUM = 6'd32;

    localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(T_W - 1);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(ACC_W - 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_START,
        ST_FETCH,
        ST_MUL,
        ST_DIVPREP,
        ST_DIV,
        ST_SQRT,
        ST_EMIT
    } t_state;

    typedef enum logic [3:0] {
        OP_LOADC,
        OP_ADDC,
        OP_MULT,
        OP_MULH,
        OP_MULA,
        OP_MULB,
        OP_SAVE0,
        OP_SAVE1,
        OP_ADDR0,
        OP_ADDR1,
        OP_DIVR,
        OP_DIVF,
        OP_SQRT,
        OP_JLH,
        OP_FIN
    } t_op;

    typedef struct packed {
        t_op op;
        logic signed [ACC_W-1:0] k;
    } t_step;

    typedef enum logic [0:0] {
        CFG_TEMP_DB = 1'b0,
        CFG_HUM_DB  = 1'b1
    } t_cfg_idx;

    function automatic t_step mk(input t_op op, input longint k);
        t_step s;
        s.op = op;
        s.k = k;
        return s;
    endfunction

    // Microprogram: Rothfusz polynomial in Horner form, the simple formula,
    // and the low-humidity correction term.
    function automatic t_step step_at(input logic [PC_W-1:0] pc);
        t_step s;
        case (pc)
            6'd0:  s = mk(OP_LOADC, -64'sd5481717 * D2);
            6'd1:  s = mk(OP_MULH, 0);
            6'd2:  s = mk(OP_ADDC, 64'sd1014333127 * D3);
            6'd3:  s = mk(OP_MULH, 0);
            6'd4:  s = mk(OP_ADDC, -64'sd4237900000 * D4);
            6'd5:  s = mk(OP_SAVE0, 0);
            6'd6:  s = mk(OP_LOADC, 64'sd85282 * D);
            6'd7:  s = mk(OP_MULH, 0);
            6'd8:  s = mk(OP_ADDC, -64'sd22475541 * D2);
            6'd9:  s = mk(OP_MULH, 0);
            6'd10: s = mk(OP_ADDC, 64'sd204901523 * D3);
            6'd11: s = mk(OP_SAVE1, 0);
            6'd12: s = mk(OP_LOADC, -64'sd199);
            6'd13: s = mk(OP_MULH, 0);
            6'd14: s = mk(OP_ADDC, 64'sd122874 * D);
            6'd15: s = mk(OP_MULH, 0);
            6'd16: s = mk(OP_ADDC, -64'sd683783 * D2);
            6'd17: s = mk(OP_MULT, 0);
            6'd18: s = mk(OP_ADDR1, 0);
            6'd19: s = mk(OP_MULT, 0);
            6'd20: s = mk(OP_ADDR0, 0);
            6'd21: s = mk(OP_DIVR, 64'sd100000000 * D3);
            6'd22: s = mk(OP_JLH, 0);
            6'd23: s = mk(OP_LOADC, 64'sd47);
            6'd24: s = mk(OP_MULH, 0);
            6'd25: s = mk(OP_ADDC, -64'sd10300 * D);
            6'd26: s = mk(OP_SAVE0, 0);
            6'd27: s = mk(OP_LOADC, 64'sd1100);
            6'd28: s = mk(OP_MULT, 0);
            6'd29: s = mk(OP_ADDR0, 0);
            6'd30: s = mk(OP_DIVR, 64'sd1000);
            6'd31: s = mk(OP_FIN, 0);
            6'd32: s = mk(OP_LOADC, 64'sd1);
            6'd33: s = mk(OP_MULA, 0);
            6'd34: s = mk(OP_MULA, 0);
            6'd35: s = mk(OP_MULB, 0);
            6'd36: s = mk(OP_DIVF, 64'sd68 * D);
            6'd37: s = mk(OP_SQRT, 0);
            default: s = mk(OP_FIN, 0);
        endcase
        return s;
    endfunction

endpackage
`default_nettype wire

>>> hdl/deadband_report_heat_index_top.sv
// Deadband temperature/humidity reporter with heat index. One sample is taken
// while the block is idle; it gives zero, one or two reports (temperature
// first, then humidity), the final one marked by tlast. Each report is
// computed by a small microsequencer around a bit-serial multiplier, a
// restoring divider (one quotient bit per cycle) and a bit-pair square root.
// A report uses the simple formula below 80 F and the Rothfusz polynomial
// otherwise, with the low-humidity correction added where it applies. A new
// sample is accepted as soon as the last report of the previous one sits in
// the output register.
`default_nettype none
module deadband_report_heat_index_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [12:0] temperature_sample, [23:13] humidity_sample
    input  wire logic [23:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [12:0] reported_temperature, [23:13] reported_humidity,
    // [38:24] heat_index, [39] zero
    output logic [39:0]      m_axis_tdata,
    output logic             m_axis_tlast,
    input  wire logic        i_cfg_we,
    input  wire logic [0:0]  i_cfg_addr,
    input  wire logic [7:0]  i_cfg_wdata
);

    localparam int T_W = dbhi_pkg::T_W;
    localparam int H_W = dbhi_pkg::H_W;
    localparam int ACC_W = dbhi_pkg::ACC_W;
    localparam int V_W = dbhi_pkg::V_W;
    localparam int SQ_W = dbhi_pkg::SQ_W;

    dbhi_pkg::t_state r_state, n_state;
    dbhi_pkg::t_step  step;

    logic [dbhi_pkg::PC_W-1:0]  r_pc;
    logic [dbhi_pkg::CNT_W-1:0] r_cnt;
    logic [dbhi_pkg::DB_W-1:0]  r_tdb, r_hdb;
    logic signed [T_W-1:0]      r_st_t, r_tin;
    logic [H_W-1:0]             r_st_h, r_hin;
    logic                       r_second;
    logic signed [ACC_W-1:0]    r_acc, r_mc, r_a0, r_a1, r_den, r_rem;
    logic [T_W-1:0]             r_x;
    logic                       r_neg, r_rnd;
    logic signed [V_W-1:0]      r_v;
    logic [dbhi_pkg::HI_W-1:0]  r_hi;
    logic [SQ_W-1:0]            r_sv, r_sr, r_sb;
    logic                       r_o_valid, r_o_last;
    logic [39:0]                r_o_data;

    logic signed [T_W+1:0] t_lo, t_hi, t_x;
    logic signed [H_W+1:0] h_lo, h_hi, h_x;
    logic                  ft, fh, lowhum, emit_ok, ld_out;
    logic signed [T_W:0]   dt;
    logic [T_W-1:0]        adt, op_a, op_b, mul_x;
    logic signed [ACC_W-1:0] rem_sh, q_raw, q_sgn;
    logic                  div_ge;
    logic [SQ_W-1:0]       sq_sum, sv_n, sr_n;
    logic                  sq_ge;
    logic signed [V_W-1:0] v_sat;

    assign step = dbhi_pkg::step_at(r_pc);

    // Deadband window tests.
    always_comb begin
        t_x  = (T_W + 2)'(r_tin);
        t_lo = (T_W + 2)'(r_st_t) - $signed((T_W + 2)'(r_tdb));
        t_hi = (T_W + 2)'(r_st_t) + $signed((T_W + 2)'(r_tdb));
        ft   = (t_x < t_lo) || (t_x > t_hi);
        h_x  = $signed((H_W + 2)'(r_hin));
        h_lo = $signed((H_W + 2)'(r_st_h)) - $signed((H_W + 2)'(r_hdb));
        h_hi = $signed((H_W + 2)'(r_st_h)) + $signed((H_W + 2)'(r_hdb));
        fh   = (h_x < h_lo) || (h_x > h_hi);
    end

    // Low-humidity correction operands and multiplier operand select.
    always_comb begin
        lowhum = (T_W'(r_st_h) < dbhi_pkg::H13) && (r_st_t >= dbhi_pkg::T80)
                 && (r_st_t <= dbhi_pkg::T112);
        dt   = (T_W + 1)'(r_st_t) - dbhi_pkg::T95;
        adt  = dt[T_W] ? T_W'(-dt) : T_W'(dt);
        op_a = dbhi_pkg::H13 - T_W'(r_st_h);
        op_b = dbhi_pkg::T17 - adt;
        case (step.op)
            dbhi_pkg::OP_MULT: mul_x = r_st_t;
            dbhi_pkg::OP_MULH: mul_x = T_W'(r_st_h);
            dbhi_pkg::OP_MULA: mul_x = op_a;
            dbhi_pkg::OP_MULB: mul_x = op_b;
            default:           mul_x = '0;
        endcase
    end

    always_comb begin
        rem_sh = {r_rem[ACC_W-2:0], r_acc[ACC_W-1]};
        div_ge = rem_sh >= r_den;
        q_raw  = {r_acc[ACC_W-2:0], div_ge};
        q_sgn  = r_neg ? -q_raw : q_raw;
        sq_sum = r_sr + r_sb;
        sq_ge  = r_sv >= sq_sum;
        sv_n   = sq_ge ? r_sv - sq_sum : r_sv;
        sr_n   = sq_ge ? (r_sr >> 1) + r_sb : r_sr >> 1;
        if (r_v < dbhi_pkg::HI_MIN) begin
            v_sat = dbhi_pkg::HI_MIN;
        end else if (r_v > dbhi_pkg::HI_MAX) begin
            v_sat = dbhi_pkg::HI_MAX;
        end else begin
            v_sat = r_v;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            dbhi_pkg::ST_IDLE:    if (s_axis_tvalid) n_state = dbhi_pkg::ST_CHECK;
            dbhi_pkg::ST_CHECK:   n_state = (ft || fh) ? dbhi_pkg::ST_START : dbhi_pkg::ST_IDLE;
            dbhi_pkg::ST_START:   n_state = dbhi_pkg::ST_FETCH;
            dbhi_pkg::ST_FETCH: begin
                case (step.op)
                    dbhi_pkg::OP_MULT, dbhi_pkg::OP_MULH,
                    dbhi_pkg::OP_MULA, dbhi_pkg::OP_MULB: n_state = dbhi_pkg::ST_MUL;
                    dbhi_pkg::OP_DIVR, dbhi_pkg::OP_DIVF: n_state = dbhi_pkg::ST_DIVPREP;
                    dbhi_pkg::OP_SQRT: n_state = dbhi_pkg::ST_SQRT;
                    dbhi_pkg::OP_FIN:  n_state = dbhi_pkg::ST_EMIT;
                    default:           n_state = dbhi_pkg::ST_FETCH;
                endcase
            end
            dbhi_pkg::ST_MUL:     if (r_cnt == dbhi_pkg::MUL_LAST) n_state = dbhi_pkg::ST_FETCH;
            dbhi_pkg::ST_DIVPREP: n_state = dbhi_pkg::ST_DIV;
            dbhi_pkg::ST_DIV:     if (r_cnt == dbhi_pkg::DIV_LAST) n_state = dbhi_pkg::ST_FETCH;
            dbhi_pkg::ST_SQRT:    if (r_sb == SQ_W'(1)) n_state = dbhi_pkg::ST_FETCH;
            dbhi_pkg::ST_EMIT: begin
                if (emit_ok) begin
                    n_state = r_second ? dbhi_pkg::ST_START : dbhi_pkg::ST_IDLE;
                end
            end
            default:              n_state = dbhi_pkg::ST_IDLE;
        endcase
    end

    // Outputs and control strobes.
    always_comb begin
        s_axis_tready = (r_state == dbhi_pkg::ST_IDLE);
        emit_ok       = !r_o_valid || m_axis_tready;
        ld_out        = (r_state == dbhi_pkg::ST_EMIT) && emit_ok;
        m_axis_tvalid = r_o_valid;
        m_axis_tdata  = r_o_data;
        m_axis_tlast  = r_o_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= dbhi_pkg::ST_IDLE;
            r_tdb     <= 8'd3;
            r_hdb     <= 8'd16;
            r_st_t    <= '0;
            r_st_h    <= '0;
            r_second  <= 1'b0;
            r_o_valid <= 1'b0;
            r_pc      <= '0;
            r_cnt     <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    dbhi_pkg::CFG_TEMP_DB: r_tdb <= i_cfg_wdata;
                    dbhi_pkg::CFG_HUM_DB:  r_hdb <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (ld_out) begin
                r_o_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                dbhi_pkg::ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_tin <= s_axis_tdata[T_W-1:0];
                        r_hin <= s_axis_tdata[T_W+H_W-1:T_W];
                    end
                end
                dbhi_pkg::ST_CHECK: begin
                    if (ft) begin
                        r_st_t   <= r_tin;
                        r_second <= fh;
                    end else if (fh) begin
                        r_st_h   <= r_hin;
                        r_second <= 1'b0;
                    end
                end
                dbhi_pkg::ST_START: begin
                    r_pc <= (r_st_t >= dbhi_pkg::T80) ? dbhi_pkg::PC_ROTH
                                                      : dbhi_pkg::PC_SIMPLE;
                end
                dbhi_pkg::ST_FETCH: begin
                    case (step.op)
                        dbhi_pkg::OP_LOADC: begin
                            r_acc <= step.k;
                            r_pc  <= r_pc + 1'b1;
                        end
                        dbhi_pkg::OP_ADDC: begin
                            r_acc <= r_acc + step.k;
                            r_pc  <= r_pc + 1'b1;
                        end
                        dbhi_pkg::OP_SAVE0: begin
                            r_a0 <= r_acc;
                            r_pc <= r_pc + 1'b1;
                        end
                        dbhi_pkg::OP_SAVE1: begin
                            r_a1 <= r_acc;
                            r_pc <= r_pc + 1'b1;
                        end
                        dbhi_pkg::OP_ADDR0: begin
                            r_acc <= r_acc + r_a0;
                            r_pc  <= r_pc + 1'b1;
                        end
                        dbhi_pkg::OP_ADDR1: begin
                            r_acc <= r_acc + r_a1;
                            r_pc  <= r_pc + 1'b1;
                        end
                        dbhi_pkg::OP_MULT, dbhi_pkg::OP_MULH,
                        dbhi_pkg::OP_MULA, dbhi_pkg::OP_MULB: begin
                            r_mc  <= r_acc;
                            r_acc <= '0;
                            r_x   <= mul_x;
                            r_cnt <= '0;
                        end
                        dbhi_pkg::OP_DIVR: begin
                            // Round to nearest, ties up: floor((2n + den) / (2 den)).
                            r_acc <= (r_acc <<< 1) + step.k;
                            r_den <= step.k <<< 1;
                            r_rnd <= 1'b1;
                        end
                        dbhi_pkg::OP_DIVF: begin
                            r_den <= step.k;
                            r_rnd <= 1'b0;
                        end
                        dbhi_pkg::OP_SQRT: begin
                            r_sv <= r_acc[SQ_W-1:0];
                            r_sr <= '0;
                            r_sb <= SQ_W'(1) << (SQ_W - 2);
                        end
                        dbhi_pkg::OP_JLH: begin
                            r_pc <= lowhum ? dbhi_pkg::PC_LOWHUM : dbhi_pkg::PC_FIN;
                        end
                        dbhi_pkg::OP_FIN: begin
                            r_hi <= v_sat[dbhi_pkg::HI_W-1:0];
                        end
                        default: ;
                    endcase
                end
                dbhi_pkg::ST_MUL: begin
                    // The top multiplier bit carries negative weight.
                    if (r_x[0]) begin
                        r_acc <= (r_cnt == dbhi_pkg::MUL_LAST) ? r_acc - r_mc : r_acc + r_mc;
                    end
                    r_mc  <= r_mc <<< 1;
                    r_x   <= r_x >> 1;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == dbhi_pkg::MUL_LAST) begin
                        r_pc <= r_pc + 1'b1;
                    end
                end
                dbhi_pkg::ST_DIVPREP: begin
                    // Floor division of a negative dividend through its magnitude.
                    r_neg <= r_acc[ACC_W-1];
                    r_acc <= r_acc[ACC_W-1] ? r_den - ACC_W'(1) - r_acc : r_acc;
                    r_rem <= '0;
                    r_cnt <= '0;
                end
                dbhi_pkg::ST_DIV: begin
                    r_rem <= div_ge ? rem_sh - r_den : rem_sh;
                    r_acc <= (r_cnt == dbhi_pkg::DIV_LAST && !r_rnd) ? q_sgn : q_raw;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == dbhi_pkg::DIV_LAST) begin
                        if (r_rnd) begin
                            r_v <= q_sgn[V_W-1:0];
                        end
                        r_pc <= r_pc + 1'b1;
                    end
                end
                dbhi_pkg::ST_SQRT: begin
                    r_sv <= sv_n;
                    r_sr <= sr_n;
                    r_sb <= r_sb >> 2;
                    if (r_sb == SQ_W'(1)) begin
                        r_v  <= r_v - V_W'((sr_n + SQ_W'(1)) >> 1);
                        r_pc <= r_pc + 1'b1;
                    end
                end
                dbhi_pkg::ST_EMIT: begin
                    if (emit_ok) begin
                        r_o_data <= {1'b0, r_hi, r_st_h, r_st_t};
                        r_o_last <= !r_second;
                        if (r_second) begin
                            r_st_h   <= r_hin;
                            r_second <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_one_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second sample accepted while the first is in work");

    a_more_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> r_state != dbhi_pkg::ST_IDLE)
        else $error("report without tlast but no further report pending");

    a_temp_only_in_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != dbhi_pkg::ST_CHECK |=> $stable(r_st_t))
        else $error("stored temperature changed outside the deadband check");

    a_hi_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> $signed(m_axis_tdata[38:24]) >= -15'sd4096)
        else $error("heat index below its saturation limit");
`endif

endmodule
`default_nettype wire
